>>> design/dvrt_pkg.sv
// Package for the distance-vector route table.
// Holds command and result codes, controller states and the control and status structs.
// No dependencies.
package dvrt_pkg;

    typedef enum logic [1:0] {
        t_CMD_ADD      = 2'd0,
        t_CMD_PACKET   = 2'd1,
        t_CMD_RESPONSE = 2'd2,
        t_CMD_NONE     = 2'd3
    } t_cmd;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_PKT   = 2'd1;
    localparam logic [1:0] KIND_ROUTE = 2'd2;
    localparam logic [1:0] KIND_EMPTY = 2'd3;

    localparam logic [1:0] REG_REFRESH  = 2'd0;
    localparam logic [1:0] REG_INFINITY = 2'd1;
    localparam logic [1:0] REG_HOP      = 2'd2;

    typedef enum logic [2:0] {
        t_ST_IDLE,
        t_ST_MARK,
        t_ST_SEARCH,
        t_ST_APPLY,
        t_ST_WALK,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic mark;
        logic search;
        logic apply;
        logic walk_start;
        logic walk_step;
        logic emit_status;
        logic emit_empty;
    } t_ctrl;

    typedef struct packed {
        logic walk_done;
        logic walk_hit;
        logic walk_any;
    } t_stat;

endpackage

>>> design/dvrt_datapath.sv
// Datapath of the distance-vector route table: slot registers, match,
// update rules, response walk and the output register.
// Depends on dvrt_pkg.
module dvrt_datapath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dvrt_pkg::t_ctrl      i_ctrl,
    output dvrt_pkg::t_stat      o_stat,
    input  logic [1:0]           i_cmd,
    input  logic [31:0]          i_nb,
    input  logic [31:0]          i_dest,
    input  logic [7:0]           i_metric,
    input  logic                 i_local,
    input  logic [7:0]           i_refresh,
    input  logic [7:0]           i_inf,
    input  logic [7:0]           i_hop,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_kind,
    output logic [31:0]          o_dest,
    output logic [7:0]           o_cost,
    output logic                 o_changed,
    output logic                 o_full,
    output logic                 o_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [TABLE_DEPTH-1:0] r_valid, r_cred, r_local;
    logic [31:0]            r_sdest [TABLE_DEPTH];
    logic [31:0]            r_shop  [TABLE_DEPTH];
    logic [7:0]             r_scost [TABLE_DEPTH];
    logic [7:0]             r_slife [TABLE_DEPTH];
    logic [CW-1:0]          r_fill;
    logic                   r_trig;

    logic [1:0]  r_cmd;
    logic [31:0] r_nb, r_dest;
    logic [7:0]  r_metric, r_newcost;
    logic        r_loc;
    logic        r_hit;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_walk;
    logic        r_any;

    logic [8:0]  w_sum;
    logic [7:0]  w_msat;
    logic        w_hit;
    logic [IW-1:0] w_idx;

    assign w_msat = (i_metric >= i_inf) ? i_inf : i_metric;
    assign w_sum  = {1'b0, w_msat} + {1'b0, i_hop};

    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (r_valid[i] && r_sdest[i] == r_dest) begin
                w_hit = 1'b1;
                w_idx = IW'(i);
            end
        end
    end

    logic [IW-1:0] w_wi;
    assign w_wi = r_walk[IW-1:0];
    assign o_stat.walk_done = (r_walk >= CW'(TABLE_DEPTH));
    assign o_stat.walk_hit  = !o_stat.walk_done && r_valid[w_wi];
    assign o_stat.walk_any  = r_any;

    logic w_full_ev;
    logic w_store;
    assign w_store = !r_hit && (r_fill < CW'(TABLE_DEPTH));
    assign w_full_ev = !r_hit && !w_store;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cred      <= '0;
            r_fill      <= '0;
            r_trig      <= 1'b0;
            o_out_valid <= 1'b0;
            r_walk      <= '0;
            r_any       <= 1'b0;
        end else begin
            if (i_ctrl.emit_status || i_ctrl.emit_empty ||
                (i_ctrl.walk_step && o_stat.walk_hit)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            if (i_ctrl.load) begin
                r_cmd     <= i_cmd;
                r_nb      <= i_nb;
                r_dest    <= i_dest;
                r_metric  <= w_msat;
                r_newcost <= (w_sum >= {1'b0, i_inf}) ? i_inf : w_sum[7:0];
                r_loc     <= i_local;
            end
            if (i_ctrl.mark) begin
                r_trig <= 1'b0;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    r_cred[i] <= r_valid[i] && r_shop[i] == r_nb;
                    if (r_valid[i] && r_shop[i] == r_nb) r_slife[i] <= i_refresh;
                end
            end
            if (i_ctrl.search) begin
                r_hit <= w_hit;
                r_idx <= w_idx;
            end
            if (i_ctrl.apply) begin
                if (r_cmd == dvrt_pkg::t_CMD_ADD) begin
                    if (r_hit) r_slife[r_idx] <= i_refresh;
                end else if (!r_hit) begin
                    if (w_store) r_trig <= 1'b1;
                end else if (r_shop[r_idx] != r_nb && !r_local[r_idx] &&
                             r_newcost < r_scost[r_idx]) begin
                    r_shop[r_idx]  <= r_nb;
                    r_scost[r_idx] <= r_newcost;
                    r_slife[r_idx] <= i_refresh;
                    r_trig         <= 1'b1;
                end else if (r_cred[r_idx] && r_shop[r_idx] == r_nb) begin
                    if (r_metric == i_inf) begin
                        if (r_scost[r_idx] != i_inf) begin
                            r_slife[r_idx] <= i_refresh;
                            r_trig         <= 1'b1;
                        end
                        r_scost[r_idx] <= i_inf;
                    end else if (r_scost[r_idx] != r_newcost) begin
                        r_scost[r_idx] <= r_newcost;
                        r_slife[r_idx] <= i_refresh;
                        r_trig         <= 1'b1;
                    end
                end
                if (w_store) begin
                    r_valid[r_fill[IW-1:0]] <= 1'b1;
                    r_cred[r_fill[IW-1:0]]  <= 1'b0;
                    r_sdest[r_fill[IW-1:0]] <= r_dest;
                    r_shop[r_fill[IW-1:0]]  <= r_nb;
                    r_scost[r_fill[IW-1:0]] <= (r_cmd == dvrt_pkg::t_CMD_ADD) ?
                                               r_metric : r_newcost;
                    r_local[r_fill[IW-1:0]] <= (r_cmd == dvrt_pkg::t_CMD_ADD) && r_loc;
                    r_slife[r_fill[IW-1:0]] <= i_refresh;
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_ctrl.emit_status) begin
                o_dest      <= '0;
                o_cost      <= '0;
                o_last      <= 1'b1;
                o_full      <= w_full_ev;
                if (r_cmd == dvrt_pkg::t_CMD_ADD) begin
                    o_kind    <= dvrt_pkg::KIND_ADD;
                    o_changed <= 1'b0;
                end else begin
                    o_kind    <= dvrt_pkg::KIND_PKT;
                    o_changed <= r_trig || w_store ||
                                 (r_hit && r_shop[r_idx] != r_nb && !r_local[r_idx] &&
                                  r_newcost < r_scost[r_idx]) ||
                                 (r_hit && !(r_shop[r_idx] != r_nb && !r_local[r_idx] &&
                                   r_newcost < r_scost[r_idx]) &&
                                  r_cred[r_idx] && r_shop[r_idx] == r_nb &&
                                  ((r_metric == i_inf) ? (r_scost[r_idx] != i_inf)
                                                       : (r_scost[r_idx] != r_newcost)));
                end
            end
            if (i_ctrl.walk_start) begin
                r_walk <= '0;
                r_any  <= 1'b0;
            end
            if (i_ctrl.walk_step) begin
                if (o_stat.walk_hit) begin
                    o_kind      <= dvrt_pkg::KIND_ROUTE;
                    o_dest      <= r_sdest[w_wi];
                    o_cost      <= (r_shop[w_wi] == r_nb && r_scost[w_wi] != 8'd0) ?
                                   i_inf : r_scost[w_wi];
                    o_changed   <= 1'b0;
                    o_full      <= 1'b0;
                    o_last      <= (r_walk + CW'(1) >= r_fill);
                    r_any       <= 1'b1;
                end
                r_walk <= r_walk + CW'(1);
            end
            if (i_ctrl.emit_empty) begin
                o_kind      <= dvrt_pkg::KIND_EMPTY;
                o_dest      <= '0;
                o_cost      <= '0;
                o_changed   <= 1'b0;
                o_full      <= 1'b0;
                o_last      <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
    a_store_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.apply && w_store |=> r_valid[$past(r_fill[IW-1:0])])
        else $error("stored slot not valid");
    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.emit_status || i_ctrl.emit_empty ||
         (i_ctrl.walk_step && o_stat.walk_hit)) |-> (!o_out_valid || i_out_ready))
        else $error("result overwritten");
`endif
endmodule

>>> design/dvrt_ctrl.sv
// Controller state machine of the distance-vector route table.
// Depends on dvrt_pkg.
module dvrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_cmd,
    input  logic            i_first,
    input  logic            i_out_busy,
    input  dvrt_pkg::t_stat i_stat,
    output dvrt_pkg::t_ctrl o_ctrl
);
    dvrt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvrt_pkg::t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            dvrt_pkg::t_ST_IDLE: begin
                o_in_ready = !i_out_busy;
                if (i_in_valid && !i_out_busy) begin
                    o_ctrl.load = 1'b1;
                    priority if (i_cmd == dvrt_pkg::t_CMD_RESPONSE) begin
                        n_state = dvrt_pkg::t_ST_WALK;
                        o_ctrl.walk_start = 1'b1;
                    end else if (i_cmd == dvrt_pkg::t_CMD_PACKET && i_first) begin
                        n_state = dvrt_pkg::t_ST_MARK;
                    end else if (i_cmd == dvrt_pkg::t_CMD_NONE) begin
                        n_state = dvrt_pkg::t_ST_IDLE;
                    end else begin
                        n_state = dvrt_pkg::t_ST_SEARCH;
                    end
                end
            end
            dvrt_pkg::t_ST_MARK: begin
                o_ctrl.mark = 1'b1;
                n_state = dvrt_pkg::t_ST_SEARCH;
            end
            dvrt_pkg::t_ST_SEARCH: begin
                o_ctrl.search = 1'b1;
                n_state = dvrt_pkg::t_ST_APPLY;
            end
            dvrt_pkg::t_ST_APPLY: begin
                o_ctrl.apply = 1'b1;
                o_ctrl.emit_status = 1'b1;
                n_state = dvrt_pkg::t_ST_IDLE;
            end
            dvrt_pkg::t_ST_WALK: begin
                if (i_stat.walk_done) begin
                    if (i_stat.walk_any) begin
                        n_state = dvrt_pkg::t_ST_IDLE;
                    end else if (!i_out_busy) begin
                        o_ctrl.emit_empty = 1'b1;
                        n_state = dvrt_pkg::t_ST_IDLE;
                    end
                end else if (!i_stat.walk_hit) begin
                    o_ctrl.walk_step = 1'b1;
                end else if (!i_out_busy) begin
                    o_ctrl.walk_step = 1'b1;
                    n_state = dvrt_pkg::t_ST_OUT;
                end
            end
            dvrt_pkg::t_ST_OUT: begin
                n_state = dvrt_pkg::t_ST_WALK;
            end
            default: n_state = dvrt_pkg::t_ST_IDLE;
        endcase
    end
endmodule

>>> design/distance_vector_route_table.sv
// Distance-vector route table, top level: APB registers, controller, datapath.
// Add and packet commands pass through search and apply states (a first packet entry
// through a mark state first) and give one status word; command 3 gives no word.
// A response walks every slot and gives one route word per valid slot.
// An empty response gives one word; output stalls hold the controller in all of these.
// Synchronous active-low reset empties the table and loads register defaults.
module distance_vector_route_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], neighbor_addr[33:2], dest_addr[65:34], route_metric[73:66],
    // is_local[74], zero fill
    input  logic [79:0] s_axis_tdata,
    input  logic        s_axis_tuser,  // first_of_packet
    input  logic        s_axis_tlast,  // last_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_kind[1:0], out_dest[33:2], out_cost[41:34], table_changed[42],
    // table_full[43], zero fill
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    logic [7:0] r_refresh, r_inf, r_hop;
    dvrt_pkg::t_ctrl w_ctrl;
    dvrt_pkg::t_stat w_stat;
    logic [1:0]  w_kind;
    logic [31:0] w_dest;
    logic [7:0]  w_cost;
    logic        w_chg, w_full;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_refresh <= 8'd12;
            r_inf     <= 8'd16;
            r_hop     <= 8'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr[3:2] == dvrt_pkg::REG_REFRESH) r_refresh <= pwdata[7:0];
            if (paddr[3:2] == dvrt_pkg::REG_INFINITY) r_inf <= pwdata[7:0];
            if (paddr[3:2] == dvrt_pkg::REG_HOP) r_hop <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[3:2] == dvrt_pkg::REG_REFRESH) prdata = {24'd0, r_refresh};
        else if (paddr[3:2] == dvrt_pkg::REG_INFINITY) prdata = {24'd0, r_inf};
        else if (paddr[3:2] == dvrt_pkg::REG_HOP) prdata = {24'd0, r_hop};
    end

    dvrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_cmd      (s_axis_tdata[1:0]),
        .i_first    (s_axis_tuser),
        .i_out_busy (m_axis_tvalid && !m_axis_tready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    dvrt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_cmd       (s_axis_tdata[1:0]),
        .i_nb        (s_axis_tdata[33:2]),
        .i_dest      (s_axis_tdata[65:34]),
        .i_metric    (s_axis_tdata[73:66]),
        .i_local     (s_axis_tdata[74]),
        .i_refresh   (r_refresh),
        .i_inf       (r_inf),
        .i_hop       (r_hop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_kind      (w_kind),
        .o_dest      (w_dest),
        .o_cost      (w_cost),
        .o_changed   (w_chg),
        .o_full      (w_full),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, w_full, w_chg, w_cost, w_dest, w_kind};
endmodule

>>> tb/tb_distance_vector_route_table.sv
// Testbench for the distance-vector route table: directed table, then random traffic.
// Predicts every output word with its own route-table model; depends on dvrt_pkg.
// Drives stream and APB ports, checks result words in order, reports pass or fail.
module tb_distance_vector_route_table;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] dest;
        logic [7:0]  cost;
        logic        changed;
        logic        full;
        logic        last;
    } t_route_word;

    typedef struct {
        dvrt_pkg::t_cmd cmd;
        logic [31:0] nbr;
        logic [31:0] dest;
        logic [7:0]  metric;
        logic        local_rt;
        logic        first;
        logic        last;
        logic        has_exp;
        t_route_word exp_word;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    distance_vector_route_table #(.TABLE_DEPTH(DEPTH)) u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]  rt_refresh, rt_inf, rt_hop;
    logic        rt_valid [DEPTH];
    logic [31:0] rt_dest [DEPTH];
    logic [31:0] rt_hop_addr [DEPTH];
    logic [7:0]  rt_cost [DEPTH];
    logic        rt_local [DEPTH];
    logic [7:0]  rt_life [DEPTH];
    logic        rt_cred [DEPTH];
    int          rt_fill;
    logic        rt_trig;

    t_route_word pending_words[$];
    int  errors = 0;
    int  n_items = 0;
    int  n_words = 0;
    int  stall_pct = 0;
    int  gap_pct = 0;
    logic [31:0] nbr_pool [4];
    logic [31:0] dest_pool [8];

    function automatic logic [7:0] clamp_cost(int c);
        return (c >= int'(rt_inf)) ? rt_inf : c[7:0];
    endfunction

    function automatic int find_route(logic [31:0] d);
        for (int i = 0; i < DEPTH; i++)
            if (rt_valid[i] && rt_dest[i] == d) return i;
        return -1;
    endfunction

    function automatic bit store_route(logic [31:0] d, logic [31:0] h, logic [7:0] c,
                                       logic l);
        if (rt_fill >= DEPTH) return 0;
        rt_valid[rt_fill] = 1; rt_dest[rt_fill] = d; rt_hop_addr[rt_fill] = h;
        rt_cost[rt_fill] = c; rt_local[rt_fill] = l; rt_life[rt_fill] = rt_refresh;
        rt_cred[rt_fill] = 0; rt_fill++;
        return 1;
    endfunction

    task automatic predict_routes(t_row r);
        t_route_word w;
        logic [7:0] metric, newcost, c;
        int s, n;
        logic full;
        metric = clamp_cost(int'(r.metric));
        w = '0;
        full = 0;
        n = 0;
        case (r.cmd)
            dvrt_pkg::t_CMD_ADD: begin
                s = find_route(r.dest);
                if (s >= 0) rt_life[s] = rt_refresh;
                else full = !store_route(r.dest, r.nbr, metric, r.local_rt);
                w.kind = dvrt_pkg::KIND_ADD; w.full = full; w.last = 1;
                pending_words.push_back(w);
            end
            dvrt_pkg::t_CMD_PACKET: begin
                newcost = clamp_cost(int'(metric) + int'(rt_hop));
                if (r.first) begin
                    rt_trig = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        rt_cred[i] = rt_valid[i] && rt_hop_addr[i] == r.nbr;
                        if (rt_cred[i]) rt_life[i] = rt_refresh;
                    end
                end
                s = find_route(r.dest);
                if (s < 0) begin
                    if (store_route(r.dest, r.nbr, newcost, 1'b0)) rt_trig = 1;
                    else full = 1;
                end else if (rt_hop_addr[s] != r.nbr && !rt_local[s] &&
                             newcost < rt_cost[s]) begin
                    rt_hop_addr[s] = r.nbr; rt_cost[s] = newcost;
                    rt_life[s] = rt_refresh; rt_trig = 1;
                end else if (rt_cred[s] && rt_hop_addr[s] == r.nbr) begin
                    if (metric == rt_inf) begin
                        if (rt_cost[s] != rt_inf) begin
                            rt_life[s] = rt_refresh; rt_trig = 1;
                        end
                        rt_cost[s] = rt_inf;
                    end else if (rt_cost[s] != newcost) begin
                        rt_cost[s] = newcost; rt_life[s] = rt_refresh; rt_trig = 1;
                    end
                end
                w.kind = dvrt_pkg::KIND_PKT; w.changed = rt_trig; w.full = full;
                w.last = 1;
                pending_words.push_back(w);
            end
            dvrt_pkg::t_CMD_RESPONSE: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (rt_valid[i]) begin
                        c = rt_cost[i];
                        if (rt_hop_addr[i] == r.nbr && c != 0) c = rt_inf;
                        w = '0; w.kind = dvrt_pkg::KIND_ROUTE; w.dest = rt_dest[i];
                        w.cost = c;
                        pending_words.push_back(w);
                        n++;
                    end
                end
                if (n == 0) begin
                    w = '0; w.kind = dvrt_pkg::KIND_EMPTY; w.last = 1;
                    pending_words.push_back(w);
                end else begin
                    w = pending_words.pop_back(); w.last = 1;
                    pending_words.push_back(w);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_route_cmd(t_row r);
        while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        predict_routes(r);
        if (r.has_exp && pending_words.size() > 0 &&
            pending_words[pending_words.size() - 1] != r.exp_word) begin
            $error("directed row: expected word %h, predicted %h", r.exp_word,
                   pending_words[pending_words.size() - 1]);
            errors++;
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, r.local_rt, r.metric, r.dest, r.nbr, r.cmd};
        s_axis_tuser  <= r.first;
        s_axis_tlast  <= r.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        n_items++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() > 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (2 * DEPTH + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00};
        pwdata <= {24'b0, val};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            dvrt_pkg::REG_REFRESH:  rt_refresh = val;
            dvrt_pkg::REG_INFINITY: rt_inf = val;
            default:                rt_hop = val;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        t_route_word got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[41:34],
                   m_axis_tdata[42], m_axis_tdata[43], m_axis_tlast};
            n_words++;
            if (pending_words.size() == 0) begin
                $error("unexpected word %h", got);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.kind != want.kind) begin
                    $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
                    errors++;
                end
                if (got.dest != want.dest) begin
                    $error("out_dest: expected %h, got %h", want.dest, got.dest);
                    errors++;
                end
                if (got.cost != want.cost) begin
                    $error("out_cost: expected %0d, got %0d", want.cost, got.cost);
                    errors++;
                end
                if (got.changed != want.changed) begin
                    $error("table_changed: expected %b, got %b", want.changed,
                           got.changed);
                    errors++;
                end
                if (got.full != want.full) begin
                    $error("table_full: expected %b, got %b", want.full, got.full);
                    errors++;
                end
                if (got.last != want.last) begin
                    $error("last_result: expected %b, got %b", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    function automatic t_row mk(dvrt_pkg::t_cmd c, logic [31:0] nb, logic [31:0] d,
                                logic [7:0] m, logic l, logic f, logic la);
        t_row r;
        r.cmd = c; r.nbr = nb; r.dest = d; r.metric = m; r.local_rt = l;
        r.first = f; r.last = la; r.has_exp = 0; r.exp_word = '0;
        return r;
    endfunction

    function automatic t_row mk_exp(t_row r, logic [1:0] k, logic ch, logic fu);
        r.has_exp = 1;
        r.exp_word = '0;
        r.exp_word.kind = k; r.exp_word.changed = ch; r.exp_word.full = fu;
        r.exp_word.last = 1;
        return r;
    endfunction

    task automatic random_phase(int count, int gp, int sp);
        t_row r;
        int pick;
        gap_pct = gp;
        stall_pct = sp;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            r = mk(dvrt_pkg::t_CMD_PACKET, nbr_pool[$urandom_range(3)],
                   dest_pool[$urandom_range(7)], 8'($urandom_range(20)), 1'b0, 1'b0, 1'b0);
            if (pick < 15) begin
                r.cmd = dvrt_pkg::t_CMD_ADD;
                r.local_rt = 1'($urandom_range(1));
                if ($urandom_range(3) == 0) r.dest = $urandom();
            end else if (pick < 25) begin
                r.cmd = dvrt_pkg::t_CMD_RESPONSE;
            end else if (pick < 30) begin
                r.cmd = dvrt_pkg::t_CMD_NONE;
                r.nbr = $urandom(); r.dest = $urandom();
            end else if (pick < 35) begin
                r.nbr = $urandom(); r.dest = $urandom(); r.metric = 8'($urandom());
            end
            r.first = $urandom_range(2) == 0;
            r.last = $urandom_range(2) == 0;
            r.local_rt = r.local_rt | ($urandom_range(9) == 0);
            send_route_cmd(r);
        end
        gap_pct = 0;
        wait_drained();
        stall_pct = 0;
    endtask

    initial begin
        t_row dir [$];
        for (int i = 0; i < DEPTH; i++) begin
            rt_valid[i] = 0; rt_cred[i] = 0; rt_dest[i] = 0; rt_hop_addr[i] = 0;
            rt_cost[i] = 0; rt_local[i] = 0; rt_life[i] = 0;
        end
        rt_fill = 0; rt_trig = 0;
        rt_refresh = 8'd12; rt_inf = 8'd16; rt_hop = 8'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        dir.push_back(mk_exp(mk(dvrt_pkg::t_CMD_RESPONSE, 32'h0, 32'h0, 8'd0,
                                1'b0, 1'b0, 1'b0), dvrt_pkg::KIND_EMPTY, 1'b0, 1'b0));
        dir.push_back(mk_exp(mk(dvrt_pkg::t_CMD_ADD, 32'h0, 32'h0, 8'd0,
                                1'b1, 1'b0, 1'b0), dvrt_pkg::KIND_ADD, 1'b0, 1'b0));
        dir.push_back(mk_exp(mk(dvrt_pkg::t_CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                                1'b0, 1'b1, 1'b1), dvrt_pkg::KIND_ADD, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_ADD, 32'hA, 32'h0, 8'd3, 1'b0, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_ADD, 32'hA, 32'h100, 8'd5, 1'b0, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                         1'b1, 1'b1, 1'b1));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hB, 32'h100, 8'd1, 1'b0, 1'b1, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hB, 32'h200, 8'hFF, 1'b0, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hB, 32'h0, 8'd0, 1'b0, 1'b0, 1'b1));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hB, 32'h100, 8'd16, 1'b0, 1'b1, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hB, 32'h100, 8'd4, 1'b0, 1'b0, 1'b1));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hC, 32'h200, 8'd15, 1'b0, 1'b0, 1'b1));
        dir.push_back(mk(dvrt_pkg::t_CMD_PACKET, 32'hFFFF_FFFF, 32'h300, 8'd0,
                         1'b0, 1'b1, 1'b1));
        dir.push_back(mk(dvrt_pkg::t_CMD_RESPONSE, 32'hB, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_RESPONSE, 32'hFFFF_FFFF, 32'h0, 8'd0,
                         1'b0, 1'b0, 1'b0));
        dir.push_back(mk(dvrt_pkg::t_CMD_RESPONSE, 32'h0, 32'h0, 8'd0, 1'b0, 1'b0, 1'b0));
        foreach (dir[k]) send_route_cmd(dir[k]);
        wait_drained();

        for (int i = 0; i < 4; i++) nbr_pool[i] = (i == 3) ? 32'hFFFF_FFFF : $urandom();
        for (int i = 0; i < 8; i++) dest_pool[i] = $urandom();
        nbr_pool[0] = 32'hB;
        dest_pool[0] = 32'h100;

        random_phase(35, 0, 0);
        random_phase(30, 49, 0);
        write_reg(dvrt_pkg::REG_REFRESH, 8'd0);
        write_reg(dvrt_pkg::REG_INFINITY, 8'd255);
        write_reg(dvrt_pkg::REG_HOP, 8'd255);
        random_phase(30, 0, 49);
        write_reg(dvrt_pkg::REG_REFRESH, 8'd255);
        write_reg(dvrt_pkg::REG_INFINITY, 8'd1);
        write_reg(dvrt_pkg::REG_HOP, 8'd0);
        random_phase(25, 7, 7);
        write_reg(dvrt_pkg::REG_INFINITY, 8'd16);
        write_reg(dvrt_pkg::REG_HOP, 8'd3);
        for (int i = 0; i < 8; i++) dest_pool[i] = $urandom();
        random_phase(20, 49, 49);

        $display("Covered %0d commands, %0d result words, table fill %0d of %0d,",
                 n_items, n_words, rt_fill, DEPTH);
        $display("with register extremes and idle phases on both stream sides.");
        if (errors == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> distance_vector_route_table.f
design/dvrt_pkg.sv
design/dvrt_datapath.sv
design/dvrt_ctrl.sv
design/distance_vector_route_table.sv
tb/tb_distance_vector_route_table.sv
